// ----- hdl/nhc_pkg.sv -----
// Shared types, constants and helpers of the Nose-Hoover chain step core.
// Used by nhc_mul, nhc_div, nhc_exp and nose_hoover_chain_step_core.
// No dependencies.
package nhc_pkg;

  localparam int CHAIN_MAX_DEF = 8;
  localparam int FX_W          = 48;
  localparam int UFX_W         = 47;
  localparam int DIV_DIGITS    = 12;

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic [UFX_W-1:0]       ufx_t;

  localparam fx_t  FX_ONE   = 48'sh0001_0000_0000;
  localparam fx_t  FX_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam fx_t  FX_MIN   = 48'sh8000_0000_0000;
  localparam ufx_t UFX_MAX  = 47'h7FFF_FFFF_FFFF;
  localparam fx_t  INV_LN2  = 48'sd6196328019;
  localparam logic signed [49:0] LN2_W   = 50'sd2977044472;
  localparam logic signed [48:0] EXP_HI  = 49'sd47244640256;
  localparam logic signed [48:0] EXP_LO  = -49'sd98784247808;

  localparam logic [1:0] CFG_CHAIN_LEN = 2'd0;
  localparam logic [1:0] CFG_TIME_STEP = 2'd1;
  localparam logic [1:0] CFG_INV_TAU2  = 2'd2;
  localparam logic [1:0] CFG_TAU2      = 2'd3;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_SQ, S_F0, S_TOP_V, S_POS, S_DN_X, S_DN_EXP, S_DN_TV, S_DN_DF,
    S_DN_DV, S_AA_X, S_AA_EXP, S_AA_M1, S_AA_M2, S_AA_F, S_UP_X, S_UP_EXP,
    S_UP_SQ, S_UP_V, S_INV_SQ, S_INV_E
  } nhc_st_e;

  typedef enum logic [2:0] {
    X_IDLE, X_Q, X_R, X_PM, X_PD, X_FIN
  } nhc_xst_e;

  typedef struct packed {
    logic start;
    fx_t  a;
    fx_t  b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    fx_t  p;
  } mul_rsp_t;

  function automatic fx_t sat48(input logic signed [49:0] v);
    fx_t r;
    if (v > 50'sd140737488355327) r = FX_MAX;
    else if (v < -50'sd140737488355328) r = FX_MIN;
    else r = v[47:0];
    return r;
  endfunction

  function automatic fx_t ufx(input ufx_t u);
    return fx_t'({1'b0, u});
  endfunction

endpackage

// ----- hdl/nose_hoover_chain_step_core.sv -----
// Nose-Hoover chain thermostat step: sequencer, oscillator state, registers.
// Instantiates nhc_mul and nhc_exp; uses nhc_pkg.
//
// Usage: write chain_length, time_step, inverse_tau_squared and tau_squared
// on the cfg port (cfg_we_i, cfg_index_i, cfg_data_i) while the core is idle.
// Raise start with cmd_i, energy_ratio_i, osc_index_i and init_velocity_i;
// the beat is taken when start is high and busy is low. busy stays high
// until the result beat: result_valid_o pulses for one cycle with
// velocity_scale_o and invariant_sum_o. The receiver cannot stall.
// Every step runs on one shared 32x32 multiplier and one exponential unit
// (range reduction, then twelve series terms, each a shared multiply plus a
// radix-16 divide). With M oscillators in use, the busy time of an advance
// is set mostly by its 2*M-1 exponentials; the result beat comes as busy
// falls. The next beat may start in the cycle of the result beat. Reset
// clears the oscillator state and loads the register defaults (M = 2,
// dt = 0, both tau terms 1.0); no clearing pass is needed.
module nose_hoover_chain_step_core #(
  parameter int CHAIN_MAX = nhc_pkg::CHAIN_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [46:0]   cfg_data_i,
  input  logic          start,
  output logic          busy,
  input  logic          cmd_i,
  input  logic [46:0]   energy_ratio_i,
  input  logic [2:0]    osc_index_i,
  input  logic signed [47:0] init_velocity_i,
  output logic          result_valid_o,
  output logic [46:0]   velocity_scale_o,
  output logic signed [47:0] invariant_sum_o
);

  localparam int IW = $clog2(CHAIN_MAX);
  localparam int LW = $clog2(CHAIN_MAX + 1);

  nhc_pkg::fx_t pos_q [CHAIN_MAX];
  nhc_pkg::fx_t vel_q [CHAIN_MAX];
  nhc_pkg::fx_t frc_q [CHAIN_MAX];

  logic [3:0]    cl_q;
  nhc_pkg::ufx_t dt_q, itau_q, tsq_q, dt2, dt4;
  logic [LW-1:0] len;
  logic [IW-1:0] last;

  nhc_pkg::nhc_st_e st_q, st_d;
  logic          iss_q, iss_d;
  logic [IW-1:0] m_q, m_d, widx_q, widx_d, va;
  nhc_pkg::fx_t  t_q, t_d, tmp_q, tmp_d, sum_q, sum_d, vin_q, vin_d;
  nhc_pkg::ufx_t aa_q, aa_d, ek_q, ek_d;
  logic          up_q, up_d, ldf_q, ldf_d;
  logic          rv_q, rv_d;
  nhc_pkg::ufx_t vs_q, vs_d;
  nhc_pkg::fx_t  inv_q, inv_d;

  logic          idx_ok, idx_up_ok, mul_op, exp_op, op_done, up_more;
  nhc_pkg::fx_t  vel_rd, frc_rd, pos_rd, half, s1;
  logic          vel_we, pos_we, frc_we;
  logic [IW-1:0] vel_wa, pos_wa, frc_wa;
  nhc_pkg::fx_t  vel_wd, pos_wd, frc_wd;

  nhc_pkg::mul_req_t mreq, mreq_top, mreq_exp;
  nhc_pkg::mul_rsp_t mrsp;
  logic              x_start, x_done;
  nhc_pkg::ufx_t     x_res;
  logic signed [48:0] x_arg;

  nhc_mul u_mul (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(mreq), .rsp_o(mrsp));

  nhc_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(x_start),
    .x_i    (x_arg),
    .mreq_o (mreq_exp),
    .mrsp_i (mrsp),
    .done_o (x_done),
    .res_o  (x_res)
  );

  // chain length in use, clamped to [2, CHAIN_MAX]
  always_comb begin
    if (cl_q < 4'd2) len = LW'(2);
    else if (32'(cl_q) > CHAIN_MAX) len = LW'(CHAIN_MAX);
    else len = LW'(cl_q);
    last = IW'(len - LW'(1));
  end

  assign dt2       = {1'b0, dt_q[46:1]};
  assign dt4       = {2'b0, dt_q[46:2]};
  assign idx_ok    = 32'(osc_index_i) < CHAIN_MAX;
  assign idx_up_ok = 32'(osc_index_i) + 32'd1 < CHAIN_MAX;
  assign up_more   = 32'(m_q) + 32'd2 < 32'(len);
  assign va        = (st_q == nhc_pkg::S_UP_X) ? m_q + IW'(1) : m_q;
  assign vel_rd    = vel_q[va];
  assign frc_rd    = frc_q[m_q];
  assign pos_rd    = pos_q[m_q];
  assign exp_op    = st_q == nhc_pkg::S_DN_EXP || st_q == nhc_pkg::S_AA_EXP ||
                     st_q == nhc_pkg::S_UP_EXP;
  assign op_done   = exp_op ? x_done : mrsp.done;
  assign mreq      = exp_op ? mreq_exp : mreq_top;
  assign x_arg     = -(49'(tmp_q));
  assign x_start   = exp_op && !iss_q;
  assign half      = mrsp.p[47] ? '0 : nhc_pkg::fx_t'({1'b0, mrsp.p[47:1]});

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      nhc_pkg::S_IDLE: begin
        if (start) begin
          if (cmd_i == nhc_pkg::CMD_LOAD) st_d = idx_ok ? nhc_pkg::S_LD_SQ : nhc_pkg::S_INV_SQ;
          else st_d = nhc_pkg::S_F0;
        end
      end
      nhc_pkg::S_LD_SQ:  if (op_done) st_d = nhc_pkg::S_INV_SQ;
      nhc_pkg::S_F0:     if (op_done) st_d = nhc_pkg::S_TOP_V;
      nhc_pkg::S_TOP_V:  if (op_done) st_d = nhc_pkg::S_POS;
      nhc_pkg::S_POS: begin
        if (op_done) st_d = (m_q != '0) ? nhc_pkg::S_DN_X : nhc_pkg::S_AA_X;
      end
      nhc_pkg::S_DN_X:   if (op_done) st_d = nhc_pkg::S_DN_EXP;
      nhc_pkg::S_DN_EXP: if (op_done) st_d = nhc_pkg::S_DN_TV;
      nhc_pkg::S_DN_TV:  if (op_done) st_d = nhc_pkg::S_DN_DF;
      nhc_pkg::S_DN_DF:  if (op_done) st_d = nhc_pkg::S_DN_DV;
      nhc_pkg::S_DN_DV:  if (op_done) st_d = up_q ? nhc_pkg::S_UP_SQ : nhc_pkg::S_POS;
      nhc_pkg::S_AA_X:   if (op_done) st_d = nhc_pkg::S_AA_EXP;
      nhc_pkg::S_AA_EXP: if (op_done) st_d = nhc_pkg::S_AA_M1;
      nhc_pkg::S_AA_M1:  if (op_done) st_d = nhc_pkg::S_AA_M2;
      nhc_pkg::S_AA_M2:  if (op_done) st_d = nhc_pkg::S_AA_F;
      nhc_pkg::S_AA_F:   if (op_done) st_d = nhc_pkg::S_UP_X;
      nhc_pkg::S_UP_X:   if (op_done) st_d = nhc_pkg::S_UP_EXP;
      nhc_pkg::S_UP_EXP: if (op_done) st_d = nhc_pkg::S_DN_TV;
      nhc_pkg::S_UP_SQ:  if (op_done) st_d = up_more ? nhc_pkg::S_UP_X : nhc_pkg::S_UP_V;
      nhc_pkg::S_UP_V:   if (op_done) st_d = nhc_pkg::S_INV_SQ;
      nhc_pkg::S_INV_SQ: if (op_done) st_d = nhc_pkg::S_INV_E;
      nhc_pkg::S_INV_E:  if (op_done) st_d = (m_q == last) ? nhc_pkg::S_IDLE : nhc_pkg::S_INV_SQ;
      default:           st_d = nhc_pkg::S_IDLE;
    endcase
  end

  // operands and writeback
  always_comb begin
    iss_d = iss_q; m_d = m_q; widx_d = widx_q; t_d = t_q; tmp_d = tmp_q;
    sum_d = sum_q; vin_d = vin_q; aa_d = aa_q; ek_d = ek_q; up_d = up_q;
    ldf_d = ldf_q; rv_d = 1'b0; vs_d = vs_q; inv_d = inv_q;
    vel_we = 1'b0; vel_wa = m_q; vel_wd = vel_rd;
    pos_we = 1'b0; pos_wa = m_q; pos_wd = pos_rd;
    frc_we = 1'b0; frc_wa = m_q; frc_wd = frc_rd;
    mreq_top = '0;
    mul_op = 1'b0;
    s1 = sum_q;
    case (st_q)
      nhc_pkg::S_IDLE: begin
        if (start) begin
          m_d = '0; sum_d = '0;
          if (cmd_i == nhc_pkg::CMD_LOAD) begin
            aa_d   = '0;
            vin_d  = init_velocity_i;
            widx_d = IW'(osc_index_i);
            ldf_d  = idx_up_ok;
            if (idx_ok) begin
              vel_we = 1'b1; vel_wa = IW'(osc_index_i); vel_wd = init_velocity_i;
              pos_we = 1'b1; pos_wa = IW'(osc_index_i); pos_wd = '0;
            end
          end else begin
            ek_d = energy_ratio_i;
            m_d  = last;
            up_d = 1'b0;
          end
        end
      end
      nhc_pkg::S_LD_SQ: begin
        mul_op = 1'b1; mreq_top.a = vin_q; mreq_top.b = vin_q;
        if (op_done && ldf_q) begin
          frc_we = 1'b1; frc_wa = widx_q + IW'(1);
          frc_wd = nhc_pkg::sat48(50'(mrsp.p) - 50'(nhc_pkg::ufx(itau_q)));
        end
      end
      nhc_pkg::S_F0: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(itau_q);
        mreq_top.b = nhc_pkg::sat48(50'(nhc_pkg::ufx(ek_q)) - 50'(nhc_pkg::FX_ONE));
        if (op_done) begin
          frc_we = 1'b1; frc_wa = '0; frc_wd = mrsp.p;
        end
      end
      nhc_pkg::S_TOP_V, nhc_pkg::S_UP_V: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(dt2); mreq_top.b = frc_rd;
        if (op_done) begin
          vel_we = 1'b1; vel_wd = nhc_pkg::sat48(50'(vel_rd) + 50'(mrsp.p));
          if (st_q == nhc_pkg::S_UP_V) begin
            m_d = '0; sum_d = '0;
          end
        end
      end
      nhc_pkg::S_POS: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(dt_q); mreq_top.b = vel_rd;
        if (op_done) begin
          pos_we = 1'b1; pos_wd = nhc_pkg::sat48(50'(pos_rd) + 50'(mrsp.p));
        end
      end
      nhc_pkg::S_DN_X, nhc_pkg::S_UP_X: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(dt4); mreq_top.b = vel_rd;
        if (op_done) tmp_d = mrsp.p;
      end
      nhc_pkg::S_DN_EXP, nhc_pkg::S_UP_EXP: begin
        if (op_done) begin
          t_d = nhc_pkg::ufx(x_res);
          // step down to the oscillator below on the way down only
          if (st_q == nhc_pkg::S_DN_EXP) m_d = m_q - IW'(1);
        end
      end
      nhc_pkg::S_DN_TV: begin
        mul_op = 1'b1; mreq_top.a = t_q; mreq_top.b = vel_rd;
        if (op_done) tmp_d = mrsp.p;
      end
      nhc_pkg::S_DN_DF: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(dt2); mreq_top.b = frc_rd;
        if (op_done) tmp_d = nhc_pkg::sat48(50'(tmp_q) + 50'(mrsp.p));
      end
      nhc_pkg::S_DN_DV: begin
        mul_op = 1'b1; mreq_top.a = t_q; mreq_top.b = tmp_q;
        if (op_done) begin
          vel_we = 1'b1; vel_wd = mrsp.p;
        end
      end
      nhc_pkg::S_AA_X: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(dt_q); mreq_top.b = vel_rd;
        if (op_done) tmp_d = mrsp.p;
      end
      nhc_pkg::S_AA_EXP: begin
        if (op_done) aa_d = x_res;
      end
      nhc_pkg::S_AA_M1: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(ek_q); mreq_top.b = nhc_pkg::ufx(aa_q);
        if (op_done) tmp_d = mrsp.p;
      end
      nhc_pkg::S_AA_M2: begin
        mul_op = 1'b1; mreq_top.a = tmp_q; mreq_top.b = nhc_pkg::ufx(aa_q);
        if (op_done) tmp_d = mrsp.p;
      end
      nhc_pkg::S_AA_F: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(itau_q);
        mreq_top.b = nhc_pkg::sat48(50'(tmp_q) - 50'(nhc_pkg::FX_ONE));
        if (op_done) begin
          frc_we = 1'b1; frc_wa = '0; frc_wd = mrsp.p;
          m_d = '0; up_d = 1'b1;
        end
      end
      nhc_pkg::S_UP_SQ: begin
        mul_op = 1'b1; mreq_top.a = vel_rd; mreq_top.b = vel_rd;
        if (op_done) begin
          frc_we = 1'b1; frc_wa = m_q + IW'(1);
          frc_wd = nhc_pkg::sat48(50'(mrsp.p) - 50'(nhc_pkg::ufx(itau_q)));
          m_d = m_q + IW'(1);
        end
      end
      nhc_pkg::S_INV_SQ: begin
        mul_op = 1'b1; mreq_top.a = vel_rd; mreq_top.b = vel_rd;
        if (op_done) tmp_d = mrsp.p;
      end
      nhc_pkg::S_INV_E: begin
        mul_op = 1'b1; mreq_top.a = nhc_pkg::ufx(tsq_q); mreq_top.b = tmp_q;
        if (op_done) begin
          tmp_d = mrsp.p;
          s1    = nhc_pkg::sat48(50'(sum_q) + 50'(half));
          sum_d = nhc_pkg::sat48(50'(s1) + 50'(pos_rd));
          if (m_q == last) begin
            rv_d = 1'b1; vs_d = aa_q; inv_d = sum_d;
          end else begin
            m_d = m_q + IW'(1);
          end
        end
      end
      default: ;
    endcase
    mreq_top.start = mul_op && !iss_q;
    if (mul_op || exp_op) begin
      iss_d = op_done ? 1'b0 : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_q   <= 4'd2;
      dt_q   <= '0;
      itau_q <= 47'h1_0000_0000;
      tsq_q  <= 47'h1_0000_0000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nhc_pkg::CFG_CHAIN_LEN: cl_q   <= cfg_data_i[3:0];
        nhc_pkg::CFG_TIME_STEP: dt_q   <= cfg_data_i;
        nhc_pkg::CFG_INV_TAU2:  itau_q <= cfg_data_i;
        nhc_pkg::CFG_TAU2:      tsq_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= nhc_pkg::S_IDLE;
      iss_q <= 1'b0;
      rv_q  <= 1'b0;
      for (int i = 0; i < CHAIN_MAX; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        frc_q[i] <= '0;
      end
    end else begin
      st_q  <= st_d;
      iss_q <= iss_d;
      rv_q  <= rv_d;
      if (pos_we) pos_q[pos_wa] <= pos_wd;
      if (vel_we) vel_q[vel_wa] <= vel_wd;
      if (frc_we) frc_q[frc_wa] <= frc_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; widx_q <= widx_d; t_q <= t_d; tmp_q <= tmp_d; sum_q <= sum_d;
    vin_q <= vin_d; aa_q <= aa_d; ek_q <= ek_d; up_q <= up_d; ldf_q <= ldf_d;
    vs_q <= vs_d; inv_q <= inv_d;
  end

  assign busy             = st_q != nhc_pkg::S_IDLE;
  assign result_valid_o   = rv_q;
  assign velocity_scale_o = vs_q;
  assign invariant_sum_o  = inv_q;

endmodule

// ----- hdl/nhc_mul.sv -----
// Shared Q16.32 multiplier: one 32x32 multiplier over four partial products.
// Rounds to nearest (ties away from zero) and saturates. Uses nhc_pkg.
module nhc_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nhc_pkg::mul_req_t req_i,
  output nhc_pkg::mul_rsp_t rsp_o
);

  logic [47:0] ma_q, ma_d, mb_q, mb_d;
  logic        neg_q, neg_d;
  logic [2:0]  ph_q, ph_d;
  logic        run_q, run_d;
  logic [64:0] acc_q, acc_d;
  nhc_pkg::fx_t res_q, res_d;
  logic        done_q, done_d;
  logic [31:0] opx, opy;
  logic [63:0] prod;

  always_comb begin
    case (ph_q)
      3'd0:    begin opx = ma_q[31:0];          opy = mb_q[31:0];          end
      3'd1:    begin opx = {16'b0, ma_q[47:32]}; opy = mb_q[31:0];          end
      3'd2:    begin opx = ma_q[31:0];          opy = {16'b0, mb_q[47:32]}; end
      default: begin opx = {16'b0, ma_q[47:32]}; opy = {16'b0, mb_q[47:32]}; end
    endcase
    prod = 64'(opx) * 64'(opy);
  end

  always_comb begin
    ma_d = ma_q; mb_d = mb_q; neg_d = neg_q; ph_d = ph_q; run_d = run_q;
    acc_d = acc_q; res_d = res_q; done_d = 1'b0;
    if (req_i.start) begin
      ma_d  = req_i.a[47] ? (~req_i.a + 48'd1) : req_i.a;
      mb_d  = req_i.b[47] ? (~req_i.b + 48'd1) : req_i.b;
      neg_d = req_i.a[47] ^ req_i.b[47];
      ph_d  = 3'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      ph_d = ph_q + 3'd1;
      case (ph_q)
        3'd0:    acc_d = (65'(prod) + 65'h0_8000_0000) >> 32;
        3'd1,
        3'd2:    acc_d = acc_q + 65'(prod);
        3'd3:    acc_d = acc_q + (65'(prod) << 32);
        default: begin
          // finish: saturate the magnitude and apply the sign
          run_d  = 1'b0;
          done_d = 1'b1;
          if (neg_q) begin
            if (acc_q >= 65'h8000_0000_0000) res_d = nhc_pkg::FX_MIN;
            else res_d = nhc_pkg::fx_t'(~acc_q[47:0] + 48'd1);
          end else begin
            if (acc_q > 65'h7FFF_FFFF_FFFF) res_d = nhc_pkg::FX_MAX;
            else res_d = nhc_pkg::fx_t'(acc_q[47:0]);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 3'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      ph_q   <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = res_q;

endmodule

// ----- hdl/nhc_div.sv -----
// Signed divide of a Q16.32 value by a small integer, truncating toward zero.
// Radix-16 restoring divider, one digit per cycle. Uses nhc_pkg.
module nhc_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  nhc_pkg::fx_t num_i,
  input  logic [3:0]   den_i,
  output logic         done_o,
  output nhc_pkg::fx_t quo_o
);

  logic [47:0] mag_q, quo_q, qfull;
  logic [3:0]  rem_q, rem_n, den_q, qd;
  logic        neg_q, run_q, done_q;
  logic [3:0]  cnt_q;
  nhc_pkg::fx_t res_q;

  always_comb begin
    logic [4:0] r5;
    rem_n = rem_q;
    qd    = 4'd0;
    for (int j = 3; j >= 0; j--) begin
      r5 = {rem_n, mag_q[44 + j]};
      if (r5 >= {1'b0, den_q}) begin
        r5    = r5 - {1'b0, den_q};
        qd[j] = 1'b1;
      end
      rem_n = r5[3:0];
    end
    qfull = {quo_q[43:0], qd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 4'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(nhc_pkg::DIV_DIGITS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= num_i[47] ? (~num_i + 48'd1) : num_i;
      neg_q <= num_i[47];
      den_q <= den_i;
      rem_q <= 4'd0;
      quo_q <= 48'd0;
    end else if (run_q) begin
      mag_q <= mag_q << 4;
      rem_q <= rem_n;
      quo_q <= qfull;
      res_q <= neg_q ? nhc_pkg::fx_t'(~qfull + 48'd1) : nhc_pkg::fx_t'(qfull);
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

// ----- hdl/nhc_exp.sv -----
// Fixed-length exponential: range reduction by ln2, 12-term Horner series,
// rounded shift by k. Borrows the shared multiplier; uses nhc_div, nhc_pkg.
module nhc_exp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [48:0]      x_i,
  output nhc_pkg::mul_req_t       mreq_o,
  input  nhc_pkg::mul_rsp_t       mrsp_i,
  output logic                    done_o,
  output nhc_pkg::ufx_t           res_o
);

  nhc_pkg::nhc_xst_e st_q, st_d;
  logic              iss_q, iss_d;
  nhc_pkg::fx_t      x_q, x_d, r_q, r_d, p_q, p_d, tmp_q, tmp_d;
  logic signed [6:0] k_q, k_d;
  logic [3:0]        n_q, n_d;
  nhc_pkg::ufx_t     res_q, res_d;
  logic              done_q, done_d;
  logic              div_start, div_done;
  nhc_pkg::fx_t      div_quo;
  logic signed [49:0] r_w;
  nhc_pkg::ufx_t     u, lim, fin;
  logic [5:0]        s;
  logic [63:0]       wide;

  nhc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (tmp_q),
    .den_i  (n_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      nhc_pkg::X_IDLE: begin
        if (start_i && x_i < nhc_pkg::EXP_HI && x_i > nhc_pkg::EXP_LO) st_d = nhc_pkg::X_Q;
      end
      nhc_pkg::X_Q:   if (mrsp_i.done) st_d = nhc_pkg::X_R;
      nhc_pkg::X_R:   st_d = nhc_pkg::X_PM;
      nhc_pkg::X_PM:  if (mrsp_i.done) st_d = nhc_pkg::X_PD;
      nhc_pkg::X_PD: begin
        if (div_done) st_d = (n_q == 4'd1) ? nhc_pkg::X_FIN : nhc_pkg::X_PM;
      end
      nhc_pkg::X_FIN: st_d = nhc_pkg::X_IDLE;
      default:        st_d = nhc_pkg::X_IDLE;
    endcase
  end

  // scale by 2^k with rounding on right shifts
  always_comb begin
    u    = p_q[47] ? '0 : p_q[46:0];
    lim  = nhc_pkg::UFX_MAX >> k_q[3:0];
    s    = 6'(-k_q);
    wide = (64'(u) + (64'd1 << (s - 6'd1))) >> s;
    if (!k_q[6]) fin = (u > lim) ? nhc_pkg::UFX_MAX : (u << k_q[3:0]);
    else         fin = wide[46:0];
    r_w = 50'(x_q) - 50'(k_q) * nhc_pkg::LN2_W;
  end

  // outputs and datapath
  always_comb begin
    iss_d = iss_q; x_d = x_q; r_d = r_q; p_d = p_q; tmp_d = tmp_q; k_d = k_q;
    n_d = n_q; res_d = res_q; done_d = 1'b0;
    mreq_o = '0;
    div_start = 1'b0;
    case (st_q)
      nhc_pkg::X_IDLE: begin
        if (start_i) begin
          x_d = x_i[47:0];
          if (x_i >= nhc_pkg::EXP_HI) begin
            res_d = nhc_pkg::UFX_MAX; done_d = 1'b1;
          end else if (x_i <= nhc_pkg::EXP_LO) begin
            res_d = '0; done_d = 1'b1;
          end
        end
      end
      nhc_pkg::X_Q: begin
        mreq_o.a = x_q; mreq_o.b = nhc_pkg::INV_LN2; mreq_o.start = !iss_q;
        iss_d = 1'b1;
        if (mrsp_i.done) begin
          k_d = mrsp_i.p[38:32];  // floor of q, arithmetic
          iss_d = 1'b0;
        end
      end
      nhc_pkg::X_R: begin
        r_d = r_w[47:0];
        p_d = nhc_pkg::FX_ONE;
        n_d = 4'd12;
      end
      nhc_pkg::X_PM: begin
        mreq_o.a = r_q; mreq_o.b = p_q; mreq_o.start = !iss_q;
        iss_d = 1'b1;
        if (mrsp_i.done) begin
          tmp_d = mrsp_i.p; iss_d = 1'b0;
        end
      end
      nhc_pkg::X_PD: begin
        div_start = !iss_q;
        iss_d = 1'b1;
        if (div_done) begin
          p_d = nhc_pkg::FX_ONE + div_quo;
          n_d = n_q - 4'd1;
          iss_d = 1'b0;
        end
      end
      nhc_pkg::X_FIN: begin
        res_d = fin; done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= nhc_pkg::X_IDLE;
      iss_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      iss_q  <= iss_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; r_q <= r_d; p_q <= p_d; tmp_q <= tmp_d; k_q <= k_d;
    n_q <= n_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
